>>> rtl/euler_vector_rotation_defines.svh
// Assertion macros shared by the rotation block.
// Expects clk and rst in the scope of each use.
`ifndef EULER_VECTOR_ROTATION_DEFINES_SVH
`define EULER_VECTOR_ROTATION_DEFINES_SVH
`ifndef SYNTHESIS
`define EVR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define EVR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`define EVR_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("assertion failed");
`else
`define EVR_ASSERT_IMPL(label, ante, cons)
`define EVR_ASSERT_NEXT(label, ante, cons)
`define EVR_ASSERT_AFTER_RESET(label, cons)
`endif
`endif

>>> rtl/evr_pkg.sv
// Types and constants of the Euler vector rotation block.
// No dependencies.
`default_nettype none
package evr_pkg;
  localparam int CORDIC_STEPS = 24;
  localparam int XW = 33;
  localparam int ZW = 32;
  localparam int FRAC_SHIFT = 30;
  localparam int K_W = 46;
  localparam int KL_W = 23;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [K_W-1:0] K_RADIANS = 46'd44798133900177;
  localparam logic [K_W-1:0] K_DEGREES = 46'd781874935307;
  localparam logic [0:0] CFG_ANGLES_IN_DEGREES = 1'b0;
  localparam logic [0:0] CFG_REVERSE_ROTATION = 1'b1;
  localparam logic [ZW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_t;
  typedef enum logic [1:0] {Q_I, Q_II, Q_III, Q_IV} quad_t;
endpackage
`default_nettype wire

>>> rtl/evr_in_if.sv
// Input channel: vector and angles with valid/ready.
// No dependencies.
`default_nettype none
interface evr_in_if #(parameter int DATA_WIDTH = 32);
  logic valid;
  logic ready;
  logic signed [DATA_WIDTH-1:0] vec_x;
  logic signed [DATA_WIDTH-1:0] vec_y;
  logic signed [DATA_WIDTH-1:0] vec_z;
  logic signed [DATA_WIDTH-1:0] roll_angle;
  logic signed [DATA_WIDTH-1:0] pitch_angle;
  logic signed [DATA_WIDTH-1:0] yaw_angle;
  modport source (output valid, vec_x, vec_y, vec_z, roll_angle, pitch_angle, yaw_angle,
                  input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, roll_angle, pitch_angle, yaw_angle,
                output ready);
endinterface
`default_nettype wire

>>> rtl/evr_out_if.sv
// Output channel: rotated vector with valid/ready.
// No dependencies.
`default_nettype none
interface evr_out_if #(parameter int DATA_WIDTH = 32);
  logic valid;
  logic ready;
  logic signed [DATA_WIDTH-1:0] rot_x;
  logic signed [DATA_WIDTH-1:0] rot_y;
  logic signed [DATA_WIDTH-1:0] rot_z;
  modport source (output valid, rot_x, rot_y, rot_z, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, output ready);
endinterface
`default_nettype wire

>>> rtl/evr_cordic_cell.sv
// One CORDIC rotation step, registered.
// Depends on evr_pkg.
`default_nettype none
module evr_cordic_cell
  import evr_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [XW-1:0] x_in,
  input  wire logic signed [XW-1:0] y_in,
  input  wire logic signed [ZW-1:0] z_in,
  output logic signed [XW-1:0]      x_out,
  output logic signed [XW-1:0]      y_out,
  output logic signed [ZW-1:0]      z_out
);
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] da;

  assign dx = y_in >>> STEP;
  assign dy = x_in >>> STEP;
  assign da = $signed(ATAN_TURNS[STEP]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[ZW-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - da;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + da;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/evr_rot_stage.sv
// Plane rotation about one axis: products, then rounded sums.
// Depends on evr_pkg.
`default_nettype none
module evr_rot_stage
  import evr_pkg::*;
#(
  parameter int VW = 34
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 valid_in,
  input  wire axis_t                axis_in,
  input  wire logic signed [VW-1:0] v_in [3],
  input  wire logic signed [XW-1:0] c_in [3],
  input  wire logic signed [XW-1:0] s_in [3],
  output logic                      valid_out,
  output logic signed [VW-1:0]      v_out [3],
  output logic signed [XW-1:0]      c_out [3],
  output logic signed [XW-1:0]      s_out [3]
);
  localparam int PW = VW + XW;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] ROUND_BIAS = SW'(64'sd536870912);

  logic [1:0] u;
  logic [1:0] w;
  logic [1:0] ai;
  logic valid_a;
  logic [1:0] ua;
  logic [1:0] wa;
  logic signed [PW-1:0] m_uc, m_ws, m_us, m_wc;
  logic signed [VW-1:0] va [3];
  logic signed [XW-1:0] ca [3];
  logic signed [XW-1:0] sa [3];
  logic signed [SW-1:0] sum_u;
  logic signed [SW-1:0] sum_w;
  logic signed [VW-1:0] nu;
  logic signed [VW-1:0] nw;

  always_comb begin
    unique case (axis_in)
      AXIS_X: begin u = 2'd1; w = 2'd2; end
      AXIS_Y: begin u = 2'd2; w = 2'd0; end
      AXIS_Z: begin u = 2'd0; w = 2'd1; end
      default: begin u = 2'd0; w = 2'd1; end
    endcase
  end
  assign ai = 2'(axis_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      valid_a <= valid_in;
      valid_out <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_uc <= v_in[u] * c_in[ai];
      m_ws <= v_in[w] * s_in[ai];
      m_us <= v_in[u] * s_in[ai];
      m_wc <= v_in[w] * c_in[ai];
      ua <= u;
      wa <= w;
      va <= v_in;
      ca <= c_in;
      sa <= s_in;
    end
  end

  assign sum_u = SW'(m_uc) - SW'(m_ws) + ROUND_BIAS;
  assign sum_w = SW'(m_us) + SW'(m_wc) + ROUND_BIAS;
  assign nu = VW'(sum_u >>> FRAC_SHIFT);
  assign nw = VW'(sum_w >>> FRAC_SHIFT);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) == ua) begin
          v_out[k] <= nu;
        end else if (2'(k) == wa) begin
          v_out[k] <= nw;
        end else begin
          v_out[k] <= va[k];
        end
      end
      c_out <= ca;
      s_out <= sa;
    end
  end
endmodule
`default_nettype wire

>>> rtl/euler_vector_rotation.sv
// Rotates a Q16.16 vector by roll, pitch and yaw (forward Rz*Ry*Rx, or the inverse
// when reverse_rotation is set). Accepts one word per cycle unless stalled, and each
// result passes the angle-scaling registers, 24 CORDIC cells per angle, the quadrant
// register, the product and sum registers of each axis rotation and the saturating
// output register. The whole pipeline holds while a finished word waits at the output.
`default_nettype none
`include "euler_vector_rotation_defines.svh"
module euler_vector_rotation
  import evr_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [0:0] cfg_data,
  evr_in_if.sink          vec_in,
  evr_out_if.source       rot_out
);
  localparam int VW = DATA_WIDTH + 2;
  localparam int MW = DATA_WIDTH + KL_W + 1;

  logic angles_in_degrees;
  logic reverse_rotation;
  logic en;
  logic out_valid;

  logic [K_W-1:0] k_sel;
  logic signed [DATA_WIDTH-1:0] ang_in [3];
  logic signed [DATA_WIDTH-1:0] vec_w [3];

  logic val0;
  logic signed [MW-1:0] pm_hi [3];
  logic signed [MW-1:0] pm_lo [3];
  logic signed [DATA_WIDTH-1:0] vec0 [3];

  logic val1;
  logic [ZW-1:0] ph1 [3];
  logic [ZW-1:0] ph_next [3];
  logic signed [DATA_WIDTH-1:0] vec1 [3];

  logic signed [XW-1:0] cx [CORDIC_STEPS][3];
  logic signed [XW-1:0] cy [CORDIC_STEPS][3];
  logic signed [ZW-1:0] cz [CORDIC_STEPS][3];
  logic cv [CORDIC_STEPS];
  quad_t squad [CORDIC_STEPS][3];
  logic signed [DATA_WIDTH-1:0] svec [CORDIC_STEPS][3];

  logic valq;
  logic signed [XW-1:0] cq [3];
  logic signed [XW-1:0] sq [3];
  logic signed [VW-1:0] vq [3];

  logic rvalid [4];
  logic signed [VW-1:0] rv [4][3];
  logic signed [XW-1:0] rc [4][3];
  logic signed [XW-1:0] rs [4][3];

  logic signed [DATA_WIDTH-1:0] rot_q [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      angles_in_degrees <= 1'b0;
      reverse_rotation <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ANGLES_IN_DEGREES: angles_in_degrees <= cfg_data[0];
        CFG_REVERSE_ROTATION:  reverse_rotation <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign en = !out_valid || rot_out.ready;
  assign vec_in.ready = en;

  assign k_sel = angles_in_degrees ? K_DEGREES : K_RADIANS;
  assign ang_in[0] = vec_in.roll_angle;
  assign ang_in[1] = vec_in.pitch_angle;
  assign ang_in[2] = vec_in.yaw_angle;
  assign vec_w[0] = vec_in.vec_x;
  assign vec_w[1] = vec_in.vec_y;
  assign vec_w[2] = vec_in.vec_z;

  // angle times scale, split in two partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        pm_hi[l] <= ang_in[l] * $signed({1'b0, k_sel[K_W-1:KL_W]});
        pm_lo[l] <= ang_in[l] * $signed({1'b0, k_sel[KL_W-1:0]});
      end
      vec0 <= vec_w;
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic signed [63:0] full;
      full = (64'(pm_hi[l]) <<< KL_W) + 64'(pm_lo[l]);
      ph_next[l] = reverse_rotation ? ZW'(-full[63:32]) : full[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph1 <= ph_next;
      vec1 <= vec0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    for (genvar l = 0; l < 3; l++) begin : g_lane
      if (i == 0) begin : g_first
        evr_cordic_cell #(.STEP(i)) u_cell (
          .clk(clk), .en(en),
          .x_in(CORDIC_GAIN), .y_in('0), .z_in({2'b00, ph1[l][ZW-3:0]}),
          .x_out(cx[i][l]), .y_out(cy[i][l]), .z_out(cz[i][l])
        );
      end else begin : g_next
        evr_cordic_cell #(.STEP(i)) u_cell (
          .clk(clk), .en(en),
          .x_in(cx[i-1][l]), .y_in(cy[i-1][l]), .z_in(cz[i-1][l]),
          .x_out(cx[i][l]), .y_out(cy[i][l]), .z_out(cz[i][l])
        );
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        squad[0][l] <= quad_t'(ph1[l][ZW-1:ZW-2]);
      end
      svec[0] <= vec1;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
        squad[i] <= squad[i-1];
        svec[i] <= svec[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val0 <= 1'b0;
      val1 <= 1'b0;
      valq <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        cv[i] <= 1'b0;
      end
    end else if (en) begin
      val0 <= vec_in.valid;
      val1 <= val0;
      cv[0] <= val1;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
        cv[i] <= cv[i-1];
      end
      valq <= cv[CORDIC_STEPS-1];
      out_valid <= rvalid[3];
    end
  end

  // map the first-quadrant result to the full turn
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        unique case (squad[CORDIC_STEPS-1][l])
          Q_I: begin
            cq[l] <= cx[CORDIC_STEPS-1][l];
            sq[l] <= cy[CORDIC_STEPS-1][l];
          end
          Q_II: begin
            cq[l] <= -cy[CORDIC_STEPS-1][l];
            sq[l] <= cx[CORDIC_STEPS-1][l];
          end
          Q_III: begin
            cq[l] <= -cx[CORDIC_STEPS-1][l];
            sq[l] <= -cy[CORDIC_STEPS-1][l];
          end
          Q_IV: begin
            cq[l] <= cy[CORDIC_STEPS-1][l];
            sq[l] <= -cx[CORDIC_STEPS-1][l];
          end
        endcase
        vq[l] <= VW'(svec[CORDIC_STEPS-1][l]);
      end
    end
  end

  assign rvalid[0] = valq;
  assign rv[0] = vq;
  assign rc[0] = cq;
  assign rs[0] = sq;

  for (genvar k = 0; k < 3; k++) begin : g_rot
    axis_t axis_k;
    assign axis_k = reverse_rotation ? axis_t'(2'(2 - k)) : axis_t'(2'(k));
    evr_rot_stage #(.VW(VW)) u_rot (
      .clk(clk), .rst(rst), .en(en),
      .valid_in(rvalid[k]), .axis_in(axis_k),
      .v_in(rv[k]), .c_in(rc[k]), .s_in(rs[k]),
      .valid_out(rvalid[k+1]),
      .v_out(rv[k+1]), .c_out(rc[k+1]), .s_out(rs[k+1])
    );
  end

  // saturate to the output width
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        if (rv[3][l][VW-1:DATA_WIDTH-1] == '0 || rv[3][l][VW-1:DATA_WIDTH-1] == '1) begin
          rot_q[l] <= rv[3][l][DATA_WIDTH-1:0];
        end else if (rv[3][l][VW-1]) begin
          rot_q[l] <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
          rot_q[l] <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
      end
    end
  end

  assign rot_out.valid = out_valid;
  assign rot_out.rot_x = rot_q[0];
  assign rot_out.rot_y = rot_q[1];
  assign rot_out.rot_z = rot_q[2];

  `EVR_ASSERT_AFTER_RESET(a_reset_empty, !out_valid && !val0 && !valq)
  `EVR_ASSERT_NEXT(a_accept_enters, vec_in.valid && vec_in.ready, val0)
  `EVR_ASSERT_NEXT(a_stall_holds, !en, $stable(valq) && $stable(cv[CORDIC_STEPS-1]))
  `EVR_ASSERT_IMPL(a_ready_when_free, !out_valid, vec_in.ready)
endmodule
`default_nettype wire
